// ===== src/lmh_pkg.sv =====
// Shared types and constants of the local maximum hotspot counter.
package lmh_pkg;

  // Default maximum row length, in cells.
  localparam int unsigned MaxWidthDefault = 1024;

  // Fixed field widths.
  localparam int unsigned CellW    = 64;
  localparam int unsigned RowW     = 16;
  localparam int unsigned WidthW   = 11;
  localparam int unsigned CntW     = 11;
  localparam int unsigned TotW     = 26;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Output queue geometry (power of two depth).
  localparam int unsigned OutDepth = 8;
  localparam int unsigned QPtrW    = $clog2(OutDepth);
  localparam int unsigned QCntW    = $clog2(OutDepth + 1);

  // Reset values of the configuration registers.
  localparam logic [WidthW-1:0] WidthReset  = WidthW'(1024);
  localparam logic [RowW-1:0]   HeightReset = RowW'(1);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } cfg_reg_e;

  // Position flags of one cell as it travels down the pipeline.
  typedef struct packed {
    logic            has_up1;   // row index at least one
    logic            has_up2;   // row index at least two
    logic            last_row;
    logic            last_col;
    logic            col_ge1;
    logic            col_ge2;
    logic [RowW-1:0] row;
  } item_ctl_t;

  // Compare results of one column against its vertical and left neighbors.
  // mid is the row above the current one, up2 the row above that.
  typedef struct packed {
    logic mu_gt;  // mid > up2
    logic cm_gt;  // cur > mid
    logic cm_lt;  // cur < mid
    logic hm_gt;  // mid > mid of the column to the left
    logic hm_lt;  // mid < mid of the column to the left
    logic hc_gt;  // cur > cur of the column to the left
    logic hc_lt;  // cur < cur of the column to the left
  } col_flags_t;

  // One result beat.
  typedef struct packed {
    logic [RowW-1:0] row_index;
    logic [CntW-1:0] row_hotspots;
    logic [TotW-1:0] total_hotspots;
    logic            last;
  } result_t;

  // Push request into the output queue.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ===== src/lmh_if.sv =====
// Valid/ready channel interfaces for cells in and row results out.
interface lmh_in_if import lmh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CellW-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface lmh_out_if import lmh_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RowW-1:0] row_index;
  logic [CntW-1:0] row_hotspots;
  logic [TotW-1:0] total_hotspots;
  logic            last;

  modport source (output valid, output row_index, output row_hotspots,
                  output total_hotspots, output last, input ready);
  modport sink   (input valid, input row_index, input row_hotspots,
                  input total_hotspots, input last, output ready);
endinterface

// ===== src/lmh_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lmh_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/lmh_column_cmp.sv =====
// Compares a fresh column of three rows with itself and with the column to its left.
module lmh_column_cmp import lmh_pkg::*; (
  input  logic             clk_i,
  input  logic             valid_i,
  input  logic [CellW-1:0] up2_i,
  input  logic [CellW-1:0] mid_i,
  input  logic [CellW-1:0] cur_i,
  output col_flags_t       flags_o
);

  logic [CellW-1:0] mid_prev_q;
  logic [CellW-1:0] cur_prev_q;

  // Hold the previous column; it is only used when the column index is not zero.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mid_prev_q <= mid_i;
      cur_prev_q <= cur_i;
    end
  end

  // All compares run side by side.
  always_comb begin
    flags_o.mu_gt = mid_i > up2_i;
    flags_o.cm_gt = cur_i > mid_i;
    flags_o.cm_lt = cur_i < mid_i;
    flags_o.hm_gt = mid_i > mid_prev_q;
    flags_o.hm_lt = mid_i < mid_prev_q;
    flags_o.hc_gt = cur_i > cur_prev_q;
    flags_o.hc_lt = cur_i < cur_prev_q;
  end

endmodule

// ===== src/lmh_row_count.sv =====
// Decides hotspots from column compare flags, keeps row counts and builds result beats.
module lmh_row_count import lmh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       restart_i,
  input  logic       valid_i,
  input  item_ctl_t  ctl_i,
  input  col_flags_t flags_i,
  output logic       valid_o,
  output push_t      push_o,
  output result_t    beat0_o,
  output result_t    beat1_o
);

  logic            s2_v_q;
  item_ctl_t       ctl_q;
  col_flags_t      cur_q;
  col_flags_t      prv_q;
  logic [CntW-1:0] pend_q, pend_d;
  logic [CntW-1:0] fin_q, fin_d;
  logic [TotW-1:0] total_q, total_d;

  logic            a_mid, a_cur, b_mid, b_cur;
  logic            emit_a, emit_b;
  logic [CntW-1:0] pend_sum, fin_sum;
  logic [TotW-1:0] total1, total2;
  result_t         beat_a, beat_b;

  // Stage register for the flags of the current column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ctl_q <= ctl_i;
      cur_q <= flags_i;
    end
    if (s2_v_q) begin
      prv_q <= cur_q;
    end
  end

  // Hotspot decisions: the column to the left, and the current one at the row end.
  always_comb begin
    a_mid = ctl_q.col_ge1 && ctl_q.has_up1 && (!ctl_q.has_up2 || prv_q.mu_gt) &&
            prv_q.cm_lt && (!ctl_q.col_ge2 || prv_q.hm_gt) && cur_q.hm_lt;
    a_cur = ctl_q.col_ge1 && ctl_q.last_row && (!ctl_q.has_up1 || prv_q.cm_gt) &&
            (!ctl_q.col_ge2 || prv_q.hc_gt) && cur_q.hc_lt;
    b_mid = ctl_q.last_col && ctl_q.has_up1 && (!ctl_q.has_up2 || cur_q.mu_gt) &&
            cur_q.cm_lt && (!ctl_q.col_ge1 || cur_q.hm_gt);
    b_cur = ctl_q.last_col && ctl_q.last_row && (!ctl_q.has_up1 || cur_q.cm_gt) &&
            (!ctl_q.col_ge1 || cur_q.hc_gt);
  end

  // Row counts and running total.
  always_comb begin
    pend_sum = pend_q + CntW'(a_mid) + CntW'(b_mid);
    fin_sum  = fin_q + CntW'(a_cur) + CntW'(b_cur);
    emit_a   = s2_v_q && ctl_q.last_col && ctl_q.has_up1;
    emit_b   = s2_v_q && ctl_q.last_col && ctl_q.last_row;
    total1   = total_q + (emit_a ? TotW'(pend_sum) : '0);
    total2   = total1 + (emit_b ? TotW'(fin_sum) : '0);

    pend_d  = pend_q;
    fin_d   = fin_q;
    total_d = total_q;
    if (restart_i) begin
      pend_d  = '0;
      fin_d   = '0;
      total_d = '0;
    end else if (s2_v_q) begin
      if (ctl_q.last_col && ctl_q.last_row) begin
        // End of the grid: start over.
        pend_d  = '0;
        fin_d   = '0;
        total_d = '0;
      end else if (ctl_q.last_col) begin
        pend_d  = '0;
        fin_d   = fin_sum;
        total_d = total1;
      end else begin
        pend_d = pend_sum;
        fin_d  = fin_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      fin_q   <= '0;
      total_q <= '0;
    end else begin
      pend_q  <= pend_d;
      fin_q   <= fin_d;
      total_q <= total_d;
    end
  end

  // Result beats: the row above settles first, then the final row.
  always_comb begin
    beat_a.row_index      = ctl_q.row - RowW'(1);
    beat_a.row_hotspots   = pend_sum;
    beat_a.total_hotspots = total1;
    beat_a.last           = 1'b0;
    beat_b.row_index      = ctl_q.row;
    beat_b.row_hotspots   = fin_sum;
    beat_b.total_hotspots = total2;
    beat_b.last           = 1'b1;

    push_o.first  = emit_a || emit_b;
    push_o.second = emit_a && emit_b;
    beat0_o       = emit_a ? beat_a : beat_b;
    beat1_o       = beat_b;
  end

  assign valid_o = s2_v_q;

endmodule

// ===== src/lmh_out_queue.sv =====
// Output queue that takes up to two result beats per cycle and sends one while the receiver is ready.
module lmh_out_queue import lmh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  input  result_t          beat0_i,
  input  result_t          beat1_i,
  input  logic             pop_ready_i,
  output logic             valid_o,
  output result_t          head_o,
  output logic [QCntW-1:0] count_o
);

  result_t          mem_q [OutDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             pop;
  logic [QPtrW-1:0] wr_ptr_next;

  assign valid_o     = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign count_o     = count_q;
  assign pop         = valid_o && pop_ready_i;
  assign wr_ptr_next = wr_ptr_q + QPtrW'(1);

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= beat0_i;
    end
    if (push_i.second) begin
      mem_q[wr_ptr_next] <= beat1_i;
    end
  end

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push_i.first) + QPtrW'(push_i.second);
    rd_ptr_d = rd_ptr_q + QPtrW'(pop);
    count_d  = count_q + QCntW'(push_i.first) + QCntW'(push_i.second) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== src/local_maximum_hotspot_counter_unit.sv =====
// A row result is queued through the read and count stage registers once its settling cell
// is taken. One cell per cycle while input is ready, set by one read-modify-write of the
// column store per cell. The output sends one beat per cycle while the receiver is ready;
// input stalls only while the output queue could overflow. Reset clears positions, counts
// and the queue; the column store is not cleared. A configuration write restarts the grid.
module local_maximum_hotspot_counter_unit import lmh_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lmh_in_if.sink              cell_i,
  lmh_out_if.source           result_o
);

  localparam int unsigned ColW  = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned WEffW = $clog2(MaxWidth + 1);
  localparam int unsigned CmpW  = WEffW + 1;

  logic [WidthW-1:0] width_q;
  logic [RowW-1:0]   height_q;
  logic              restart;

  logic [WEffW-1:0]  w_eff;
  logic [RowW-1:0]   h_eff;
  logic [ColW-1:0]   col_pos_q;
  logic [RowW-1:0]   row_pos_q;
  logic              accept;
  item_ctl_t         ctl_d;

  logic              s1_v_q;
  logic [CellW-1:0]  s1_cell_q;
  logic [ColW-1:0]   s1_col_q;
  item_ctl_t         s1_ctl_q;
  logic              fwd_q;
  logic [2*CellW-1:0] fwd_data_q;
  logic [2*CellW-1:0] ram_rdata;
  logic [2*CellW-1:0] ram_wdata;
  logic [2*CellW-1:0] col_data;

  col_flags_t        flags;
  logic              s2_v;
  push_t             push;
  result_t           beat0, beat1, head;
  logic [QCntW-1:0]  q_count;
  logic              in_ready;

  // Configuration registers; any write restarts the grid.
  assign restart = cfg_we_i && (cfg_reg_e'(cfg_idx_i) inside {RegImageWidth, RegImageHeight});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegImageWidth:  width_q  <= cfg_data_i[WidthW-1:0];
        RegImageHeight: height_q <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size with out-of-range values clamped.
  always_comb begin
    if (width_q == '0) begin
      w_eff = WEffW'(1);
    end else if (int'(width_q) > int'(MaxWidth)) begin
      w_eff = WEffW'(MaxWidth);
    end else begin
      w_eff = WEffW'(width_q);
    end
    h_eff = (height_q == '0) ? RowW'(1) : height_q;
  end

  // Position of the incoming cell.
  assign accept = cell_i.valid && in_ready;

  always_comb begin
    ctl_d.row      = row_pos_q;
    ctl_d.has_up1  = row_pos_q != '0;
    ctl_d.has_up2  = row_pos_q > RowW'(1);
    ctl_d.col_ge1  = col_pos_q != '0;
    ctl_d.col_ge2  = col_pos_q > ColW'(1);
    ctl_d.last_col = (CmpW'(col_pos_q) + CmpW'(1)) == CmpW'(w_eff);
    ctl_d.last_row = ((RowW + 1)'(row_pos_q) + (RowW + 1)'(1)) == (RowW + 1)'(h_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else if (restart) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else if (accept) begin
      if (ctl_d.last_col) begin
        col_pos_q <= '0;
        row_pos_q <= ctl_d.last_row ? '0 : row_pos_q + RowW'(1);
      end else begin
        col_pos_q <= col_pos_q + ColW'(1);
      end
    end
  end

  // Read stage: the column store is read at the cell's column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cell_q <= cell_i.cell_value;
      s1_col_q  <= col_pos_q;
      s1_ctl_q  <= ctl_d;
    end
    // Forward a write that lands on the column being read in the same cycle.
    fwd_q      <= s1_v_q && (s1_col_q == col_pos_q);
    fwd_data_q <= ram_wdata;
  end

  // Each entry holds the two latest rows of a column: newer word on top.
  lmh_ram #(
    .Width (2 * CellW),
    .Depth (MaxWidth)
  ) u_col_store (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wdata),
    .raddr_i (col_pos_q),
    .rdata_o (ram_rdata)
  );

  assign col_data  = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_wdata = {s1_cell_q, col_data[2*CellW-1:CellW]};

  // Compare stage.
  lmh_column_cmp u_cmp (
    .clk_i   (clk_i),
    .valid_i (s1_v_q),
    .up2_i   (col_data[CellW-1:0]),
    .mid_i   (col_data[2*CellW-1:CellW]),
    .cur_i   (s1_cell_q),
    .flags_o (flags)
  );

  // Decision and count stage.
  lmh_row_count u_count (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .valid_i   (s1_v_q),
    .ctl_i     (s1_ctl_q),
    .flags_i   (flags),
    .valid_o   (s2_v),
    .push_o    (push),
    .beat0_o   (beat0),
    .beat1_o   (beat1)
  );

  // Output queue.
  lmh_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .beat0_i     (beat0),
    .beat1_i     (beat1),
    .pop_ready_i (result_o.ready),
    .valid_o     (result_o.valid),
    .head_o      (head),
    .count_o     (q_count)
  );

  assign result_o.row_index      = head.row_index;
  assign result_o.row_hotspots   = head.row_hotspots;
  assign result_o.total_hotspots = head.total_hotspots;
  assign result_o.last           = head.last;

  // Take a cell only when the queue has room for every beat still in flight.
  assign in_ready = (int'(q_count) + 2 * (int'(s1_v_q) + int'(s2_v) + 1)) <= int'(OutDepth);
  assign cell_i.ready = in_ready;

endmodule

// ===== tb/lmh_row_count_checker.sv =====
// Checker that predicts and compares the row results of the local maximum hotspot counter.
module lmh_row_count_checker import lmh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lmh_in_if                   cell_i,
  lmh_out_if                  result_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         rows_due_o,
  output int unsigned         rows_checked_o
);

  localparam int unsigned StoreDepth = MaxWidthDefault;

  // Two rows of cells, indexed by row parity and column.
  logic [CellW-1:0]  line_rows [2][StoreDepth];
  logic [WidthW-1:0] width_reg;
  logic [RowW-1:0]   height_reg;
  int unsigned       col_at;
  int unsigned       row_at;
  int unsigned       open_row_peaks;
  int unsigned       bottom_row_peaks;
  logic [CellW-1:0]  left_cell;
  logic [TotW-1:0]   grid_total;
  result_t           rows_due [$];
  result_t           want;

  // A cell is a hotspot when no existing neighbor reaches its value.
  function automatic bit is_hotspot(input logic [CellW-1:0] ctr,
                                    input bit hu, input logic [CellW-1:0] up,
                                    input bit hd, input logic [CellW-1:0] dn,
                                    input bit hl, input logic [CellW-1:0] lf,
                                    input bit hr, input logic [CellW-1:0] rt);
    if (hu && up >= ctr) return 1'b0;
    if (hd && dn >= ctr) return 1'b0;
    if (hl && lf >= ctr) return 1'b0;
    if (hr && rt >= ctr) return 1'b0;
    return 1'b1;
  endfunction

  task automatic restart_grid();
    col_at           = 0;
    row_at           = 0;
    open_row_peaks   = 0;
    bottom_row_peaks = 0;
    left_cell        = '0;
    grid_total       = '0;
  endtask

  // Add a settled row to the running total and queue its result.
  task automatic log_row(input int unsigned row, input int unsigned peaks, input bit is_last);
    result_t r;
    grid_total       = grid_total + TotW'(peaks);
    r.row_index      = RowW'(row);
    r.row_hotspots   = CntW'(peaks);
    r.total_hotspots = grid_total;
    r.last           = is_last;
    rows_due.push_back(r);
  endtask

  // Settle whatever the new cell decides and queue the rows it completes.
  task automatic take_cell(input logic [CellW-1:0] v);
    int unsigned      w;
    int unsigned      h;
    int unsigned      r;
    int unsigned      c;
    bit               last_row;
    bit               last_col;
    bit               hu;
    bit               hl;
    bit               hr;
    logic [CellW-1:0] ctr;
    logic [CellW-1:0] up;
    logic [CellW-1:0] lf;
    logic [CellW-1:0] rt;
    w = (width_reg == '0) ? 1 : ((width_reg > StoreDepth) ? StoreDepth : width_reg);
    h = (height_reg == '0) ? 1 : height_reg;
    r = row_at;
    c = col_at;
    last_row = (r + 1 == h);
    last_col = (c + 1 == w);

    // The cell above is decided now that its lower neighbor is known.
    if (r > 0) begin
      ctr = line_rows[(r - 1) % 2][c];
      hu  = (r >= 2);
      hl  = (c > 0);
      hr  = !last_col;
      up  = '0;
      lf  = '0;
      rt  = '0;
      if (hu) up = line_rows[r % 2][c];
      if (hl) lf = line_rows[(r - 1) % 2][c - 1];
      if (hr) rt = line_rows[(r - 1) % 2][c + 1];
      if (is_hotspot(ctr, hu, up, 1'b1, v, hl, lf, hr, rt)) open_row_peaks++;
    end

    line_rows[r % 2][c] = v;

    // In the bottom row the left cell settles now, and the row end settles itself.
    if (last_row) begin
      hu = (r > 0);
      if (c > 0) begin
        hl = (c > 1);
        up = '0;
        lf = '0;
        if (hu) up = line_rows[(r - 1) % 2][c - 1];
        if (hl) lf = line_rows[r % 2][c - 2];
        if (is_hotspot(left_cell, hu, up, 1'b0, '0, hl, lf, 1'b1, v)) bottom_row_peaks++;
      end
      if (last_col) begin
        up = '0;
        if (hu) up = line_rows[(r - 1) % 2][c];
        if (is_hotspot(v, hu, up, 1'b0, '0, c > 0, left_cell, 1'b0, '0)) bottom_row_peaks++;
      end
    end

    left_cell = v;

    if (last_col && r > 0) begin
      log_row(r - 1, open_row_peaks, 1'b0);
      open_row_peaks = 0;
    end

    if (last_col && last_row) begin
      log_row(r, bottom_row_peaks, 1'b1);
      restart_grid();
    end else if (last_col) begin
      col_at = 0;
      row_at = (r + 1) & 16'hFFFF;
    end else begin
      col_at = c + 1;
    end
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_due.delete();
      width_reg        = WidthReset;
      height_reg       = HeightReset;
      mismatch_count_o = 0;
      rows_checked_o   = 0;
      restart_grid();
    end else begin
      if (cell_i.valid && cell_i.ready) take_cell(cell_i.cell_value);

      // Each result beat is held against the oldest expected row.
      if (result_i.valid && result_i.ready) begin
        if (rows_due.size() == 0) begin
          $error("unexpected result beat for row %0d", result_i.row_index);
          mismatch_count_o++;
        end else begin
          want = rows_due.pop_front();
          rows_checked_o++;
          if (result_i.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, result_i.row_index);
            mismatch_count_o++;
          end
          if (result_i.row_hotspots !== want.row_hotspots) begin
            $error("row_hotspots: expected %0d, got %0d",
                   want.row_hotspots, result_i.row_hotspots);
            mismatch_count_o++;
          end
          if (result_i.total_hotspots !== want.total_hotspots) begin
            $error("total_hotspots: expected %0d, got %0d",
                   want.total_hotspots, result_i.total_hotspots);
            mismatch_count_o++;
          end
          if (result_i.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result_i.last);
            mismatch_count_o++;
          end
        end
      end

      // A register write stores the value and starts a fresh grid.
      if (cfg_we_i) begin
        if (cfg_idx_i == RegImageWidth) width_reg = cfg_data_i[WidthW-1:0];
        else height_reg = cfg_data_i[RowW-1:0];
        restart_grid();
      end
    end
    rows_due_o = rows_due.size();
  end

endmodule

// ===== tb/tb_local_maximum_hotspot_counter_unit.sv =====
// Stimulus and verdict for the local maximum hotspot counter.
module tb_local_maximum_hotspot_counter_unit;
  import lmh_pkg::*;

  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned RandomCells   = 120;
  // About 1300 cells; the run stays far below this limit.
  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned PadW          = CfgDataW - WidthW;

  typedef enum int {ValSmall, ValWide, ValEdge} cell_style_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;
  int unsigned cells_sent = 0;
  int unsigned grids_set = 0;
  int unsigned cur_w = MaxWidthDefault;
  int unsigned cur_h = 1;
  int unsigned mismatches;
  int unsigned rows_due;
  int unsigned rows_checked;

  lmh_in_if  cell_if ();
  lmh_out_if res_if ();

  local_maximum_hotspot_counter_unit uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .cell_i    (cell_if),
    .result_o  (res_if)
  );

  lmh_row_count_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .cell_i          (cell_if),
    .result_i        (res_if),
    .mismatch_count_o(mismatches),
    .rows_due_o      (rows_due),
    .rows_checked_o  (rows_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard limit on the whole run.
  initial begin
    #(4 * TimeoutCycles);
    $display("FAIL");
    $finish;
  end

  // Result side: random stalls, plus long hold-offs on request.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [CellW-1:0] pick_cell(input cell_style_e s);
    logic [CellW-1:0] v;
    case (s)
      ValSmall: v = CellW'($urandom_range(0, 3));
      ValWide:  v = {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = '1;
          2:       v = {32'hFFFF_FFFF, $urandom};
          3:       v = {1'b1, 63'd0} | CellW'($urandom_range(0, 1));
          default: v = '1 - CellW'($urandom_range(1, 2));
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Offer one cell and return at the edge that takes it, with valid still high.
  task automatic send_cell(input logic [CellW-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cell_if.valid <= 1'b0;
      @(posedge clk);
    end
    cell_if.valid      <= 1'b1;
    cell_if.cell_value <= v;
    @(posedge clk);
    while (!cell_if.ready) @(posedge clk);
    cells_sent++;
  endtask

  // Stop offering and wait until every expected row has come back.
  task automatic drain();
    cell_if.valid <= 1'b0;
    @(posedge clk);
    while (rows_due != 0) @(posedge clk);
  endtask

  // Write both registers once the block has gone quiet.
  task automatic set_grid(input int unsigned w, input int unsigned h);
    drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegImageWidth;
    cfg_data <= {PadW'($urandom_range(0, 31)), WidthW'(w)};
    @(posedge clk);
    cfg_idx  <= RegImageHeight;
    cfg_data <= RowW'(h);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_w = (w == 0) ? 1 : ((w > MaxWidthDefault) ? MaxWidthDefault : w);
    cur_h = (h == 0) ? 1 : h;
    grids_set++;
  endtask

  initial begin
    int unsigned  random_cells;
    int unsigned  grid_no;
    int unsigned  w;
    int unsigned  h;
    int unsigned  sel;
    int unsigned  cells;
    int unsigned  cut;
    int unsigned  pause_at;
    bit           must_cfg;
    cell_style_e  style;

    random_cells = 0;
    grid_no      = 0;
    must_cfg     = 1'b1;
    cell_if.valid      <= 1'b0;
    cell_if.cell_value <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= RegImageWidth;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset settings give one full-width row.
    for (int unsigned i = 0; i < MaxWidthDefault; i++) send_cell(pick_cell(ValSmall));

    // Single cell grids from zero sizes, at both value extremes.
    set_grid(0, 0);
    send_cell('1);
    send_cell('0);

    // Three by three with ties, the largest values and a clear peak.
    set_grid(3, 3);
    send_cell(64'd5); send_cell(64'd5); send_cell(64'd1);
    send_cell(64'd0); send_cell('1);    send_cell('1 - 64'd1);
    send_cell(64'd7); send_cell(64'd0); send_cell(64'd7);

    // One column, one row, and a flat square.
    set_grid(1, 3);
    send_cell(64'd0); send_cell(64'd1); send_cell(64'd0);
    set_grid(4, 1);
    send_cell(64'd1); send_cell(64'd1); send_cell(64'd2); send_cell(64'd0);
    set_grid(2, 2);
    repeat (4) send_cell('0);

    // An oversized width, cut short by the next register write.
    set_idling(0, 79);
    set_grid(2047, 2);
    repeat (40) send_cell(pick_cell(ValSmall));

    // The tallest grid, cut short by the next register write.
    set_idling(29, 29);
    set_grid(1, 65535);
    repeat (40) send_cell(pick_cell(ValEdge));

    // Results held back long enough to fill the block, then a pause mid-grid.
    set_idling(0, 0);
    set_grid(1, 40);
    hold_reqs++;
    for (int unsigned i = 0; i < 40; i++) begin
      send_cell(pick_cell(ValSmall));
      if (i == 20) drain();
    end

    // Random grids, mostly small, under rotating idle patterns.
    while (random_cells < RandomCells) begin
      grid_no++;
      case (grid_no % 5)
        1:       set_idling(79, 0);
        2:       set_idling(0, 79);
        3:       set_idling(29, 29);
        default: set_idling(0, 0);
      endcase
      if (must_cfg || $urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 99);
        h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        if (sel < 4) begin
          w = 0;
        end else if (sel < 14) begin
          w = $urandom_range(9, 40);
          h = $urandom_range(1, 3);
        end else begin
          w = $urandom_range(1, 8);
        end
        set_grid(w, h);
      end
      must_cfg = 1'b0;
      style = cell_style_e'($urandom_range(0, 2));
      cells = cur_w * cur_h;
      cut   = cells;
      if ($urandom_range(0, 9) == 0) begin
        cut      = $urandom_range(1, cells);
        must_cfg = 1'b1;
      end
      pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cut) : 0;
      for (int unsigned i = 1; i <= cut; i++) begin
        send_cell(pick_cell(style));
        if (i == pause_at) drain();
      end
      random_cells += cut;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d cells over %0d register settings and %0d random grids,",
             cells_sent, grids_set, grid_no);
    $display("with %0d row results compared, size limits, long hold-offs and pauses.",
             rows_checked);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
